/* hw/rtl/bei_pkg.sv */
// Package: shared types, datapath operation codes and curve constants.
`default_nettype none
package bei_pkg;

  typedef struct packed {
    logic        cmd;
    logic [31:0] time_req;
    logic [15:0] level;
    logic [2:0]  curve;
  } bei_in_t;

  typedef struct packed {
    logic [15:0] sample;
    logic        accepted;
  } bei_out_t;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_ADD    = 1'b1;

  localparam logic [2:0] CURVE_STEP     = 3'd0;
  localparam logic [2:0] CURVE_LINEAR   = 3'd1;
  localparam logic [2:0] CURVE_COSINE   = 3'd2;
  localparam logic [2:0] CURVE_EASE_IN  = 3'd3;
  localparam logic [2:0] CURVE_EASE_OUT = 3'd4;

  // datapath operations
  localparam logic [4:0] OP_NONE       = 5'd0;
  localparam logic [4:0] OP_LATCH      = 5'd1;
  localparam logic [4:0] OP_CLEAR      = 5'd2;
  localparam logic [4:0] OP_RD_LAST    = 5'd3;
  localparam logic [4:0] OP_POP        = 5'd4;
  localparam logic [4:0] OP_APPEND     = 5'd5;
  localparam logic [4:0] OP_SAMP_BEGIN = 5'd6;
  localparam logic [4:0] OP_RD_CUR     = 5'd7;
  localparam logic [4:0] OP_CUR_INC    = 5'd8;
  localparam logic [4:0] OP_LOAD_END   = 5'd9;
  localparam logic [4:0] OP_RD_PREV    = 5'd10;
  localparam logic [4:0] OP_LOAD_PREV  = 5'd11;
  localparam logic [4:0] OP_DIV_INIT   = 5'd12;
  localparam logic [4:0] OP_DIV_STEP   = 5'd13;
  localparam logic [4:0] OP_W_LIN      = 5'd14;
  localparam logic [4:0] OP_CUBE_PRE   = 5'd15;
  localparam logic [4:0] OP_MUL_XX     = 5'd16;
  localparam logic [4:0] OP_CUBE_F2    = 5'd17;
  localparam logic [4:0] OP_MUL_YX     = 5'd18;
  localparam logic [4:0] OP_CUBE_FIN   = 5'd19;
  localparam logic [4:0] OP_COS_U      = 5'd20;
  localparam logic [4:0] OP_MUL_XPI    = 5'd21;
  localparam logic [4:0] OP_SHX        = 5'd22;
  localparam logic [4:0] OP_SHY        = 5'd23;
  localparam logic [4:0] OP_MUL_YA     = 5'd24;
  localparam logic [4:0] OP_HORNER     = 5'd25;
  localparam logic [4:0] OP_COS_FIN    = 5'd26;
  localparam logic [4:0] OP_MUL_FIN    = 5'd27;
  localparam logic [4:0] OP_RESULT     = 5'd28;
  localparam logic [4:0] OP_RES_L0     = 5'd29;
  localparam logic [4:0] OP_RES_LAST   = 5'd30;
  localparam logic [4:0] OP_RES_START  = 5'd31;

  typedef struct packed {
    logic [4:0] op;
    logic       emit;
    logic       ok;
  } bei_cmd_t;

  typedef struct packed {
    logic       is_add;
    logic       t_zero;
    logic       cnt_zero;
    logic       cnt_full;
    logic       cur_end;
    logic       cur_zero;
    logic       t_lt_r;
    logic       div_skip;
    logic       div_last;
    logic       horner_done;
    logic [2:0] curve;
  } bei_stat_t;

  // Q30 constants for the cosine series
  localparam logic [31:0] Q30_ONE  = 32'h4000_0000;
  localparam logic [31:0] Q30_HALF = 32'h2000_0000;
  localparam logic [31:0] PI_Q30   = 32'd3373259426;
  localparam logic [31:0] CS_C1    = 32'd268435456;
  localparam logic [31:0] CS_C2    = 32'd22369621;
  localparam logic [31:0] CS_C3    = 32'd745654;
  localparam logic [31:0] CS_C4    = 32'd13315;
  localparam logic [31:0] CS_C5    = 32'd148;
  localparam logic [2:0]  HORNER_STEPS = 3'd4;

  function automatic logic [31:0] horner_coef(input logic [1:0] k);
    logic [31:0] c;
    case (k)
      2'd0:    c = CS_C4;
      2'd1:    c = CS_C3;
      2'd2:    c = CS_C2;
      default: c = CS_C1;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/bei_ctrl.sv */
// Controller: sequences table updates, cursor walk, division and weighting.
`default_nettype none
module bei_ctrl import bei_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  output logic           busy_o,
  input  wire bei_stat_t stat_i,
  output bei_cmd_t       cmd_o
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_POP_RD  = 5'd2;
  localparam logic [4:0] S_POP_CK  = 5'd3;
  localparam logic [4:0] S_APP     = 5'd4;
  localparam logic [4:0] S_WALK_RD = 5'd5;
  localparam logic [4:0] S_WALK_CK = 5'd6;
  localparam logic [4:0] S_LAST    = 5'd7;
  localparam logic [4:0] S_PREV_RD = 5'd8;
  localparam logic [4:0] S_PREV_LD = 5'd9;
  localparam logic [4:0] S_DIVI    = 5'd10;
  localparam logic [4:0] S_DIVS    = 5'd11;
  localparam logic [4:0] S_WSEL    = 5'd12;
  localparam logic [4:0] S_K1      = 5'd13;
  localparam logic [4:0] S_K2      = 5'd14;
  localparam logic [4:0] S_K3      = 5'd15;
  localparam logic [4:0] S_K4      = 5'd16;
  localparam logic [4:0] S_C1      = 5'd17;
  localparam logic [4:0] S_C2      = 5'd18;
  localparam logic [4:0] S_C3      = 5'd19;
  localparam logic [4:0] S_C4      = 5'd20;
  localparam logic [4:0] S_C5      = 5'd21;
  localparam logic [4:0] S_C6      = 5'd22;
  localparam logic [4:0] S_FMUL    = 5'd23;
  localparam logic [4:0] S_FRES    = 5'd24;
  localparam logic [4:0] S_EMIT    = 5'd25;

  logic [4:0] state_q, state_d;
  logic       ok_q, ok_d;
  logic [4:0] op;

  always_comb begin
    state_d = state_q;
    ok_d    = ok_q;
    op      = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op      = OP_LATCH;
          ok_d    = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (stat_i.is_add) begin
          if (stat_i.t_zero) begin
            op      = OP_CLEAR;
            state_d = S_EMIT;
          end else begin
            state_d = S_POP_RD;
          end
        end else if (stat_i.cnt_zero) begin
          op      = OP_RES_START;
          state_d = S_EMIT;
        end else begin
          op      = OP_SAMP_BEGIN;
          state_d = S_WALK_RD;
        end
      end
      S_POP_RD: begin
        if (stat_i.cnt_zero) begin
          state_d = S_APP;
        end else begin
          op      = OP_RD_LAST;
          state_d = S_POP_CK;
        end
      end
      S_POP_CK: begin
        if (stat_i.t_lt_r) begin
          op      = OP_POP;
          state_d = S_POP_RD;
        end else begin
          state_d = S_APP;
        end
      end
      S_APP: begin
        if (stat_i.cnt_full) begin
          ok_d = 1'b0;
        end else begin
          op = OP_APPEND;
        end
        state_d = S_EMIT;
      end
      S_WALK_RD: begin
        if (stat_i.cur_end) begin
          op      = OP_RD_LAST;
          state_d = S_LAST;
        end else begin
          op      = OP_RD_CUR;
          state_d = S_WALK_CK;
        end
      end
      S_LAST: begin
        op      = OP_RES_LAST;
        state_d = S_EMIT;
      end
      S_WALK_CK: begin
        if (!stat_i.t_lt_r) begin
          op      = OP_CUR_INC;
          state_d = S_WALK_RD;
        end else begin
          op      = OP_LOAD_END;
          state_d = stat_i.cur_zero ? S_DIVI : S_PREV_RD;
        end
      end
      S_PREV_RD: begin
        op      = OP_RD_PREV;
        state_d = S_PREV_LD;
      end
      S_PREV_LD: begin
        op      = OP_LOAD_PREV;
        state_d = S_DIVI;
      end
      S_DIVI: begin
        op      = OP_DIV_INIT;
        state_d = stat_i.div_skip ? S_WSEL : S_DIVS;
      end
      S_DIVS: begin
        op = OP_DIV_STEP;
        if (stat_i.div_last) state_d = S_WSEL;
      end
      S_WSEL: begin
        case (stat_i.curve)
          CURVE_LINEAR: begin
            op      = OP_W_LIN;
            state_d = S_FMUL;
          end
          CURVE_COSINE: begin
            op      = OP_COS_U;
            state_d = S_C1;
          end
          CURVE_EASE_IN, CURVE_EASE_OUT: begin
            op      = OP_CUBE_PRE;
            state_d = S_K1;
          end
          default: begin
            op      = OP_RES_L0;
            state_d = S_EMIT;
          end
        endcase
      end
      S_K1: begin op = OP_MUL_XX;   state_d = S_K2;   end
      S_K2: begin op = OP_CUBE_F2;  state_d = S_K3;   end
      S_K3: begin op = OP_MUL_YX;   state_d = S_K4;   end
      S_K4: begin op = OP_CUBE_FIN; state_d = S_FMUL; end
      S_C1: begin op = OP_MUL_XPI;  state_d = S_C2;   end
      S_C2: begin op = OP_SHX;      state_d = S_C3;   end
      S_C3: begin op = OP_MUL_XX;   state_d = S_C4;   end
      S_C4: begin op = OP_SHY;      state_d = S_C5;   end
      S_C5: begin op = OP_MUL_YA;   state_d = S_C6;   end
      S_C6: begin
        if (stat_i.horner_done) begin
          op      = OP_COS_FIN;
          state_d = S_FMUL;
        end else begin
          op      = OP_HORNER;
          state_d = S_C5;
        end
      end
      S_FMUL: begin op = OP_MUL_FIN; state_d = S_FRES; end
      S_FRES: begin op = OP_RESULT;  state_d = S_EMIT; end
      S_EMIT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ok_q    <= 1'b1;
    end else begin
      state_q <= state_d;
      ok_q    <= ok_d;
    end
  end

  assign busy_o     = (state_q != S_IDLE);
  assign cmd_o.op   = op;
  assign cmd_o.emit = (state_q == S_EMIT);
  assign cmd_o.ok   = ok_q;

endmodule
`default_nettype wire

/* hw/rtl/bei_dp.sv */
// Datapath: breakpoint table, cursor, serial divider, shared multiplier, output register.
`default_nettype none
module bei_dp import bei_pkg::*; #(
  parameter int MAX_POINTS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire bei_in_t  in_i,
  input  wire bei_cmd_t cmd_i,
  output bei_stat_t     stat_o,
  output logic          strobe_o,
  output bei_out_t      out_o
);

  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int IW  = $clog2(MAX_POINTS);
  localparam int DCW = $clog2(FRAC_BITS);
  localparam int FW  = FRAC_BITS + 1;
  localparam int AW  = FRAC_BITS + 18;
  localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;

  // table
  logic [31:0] time_mem  [MAX_POINTS];
  logic [15:0] level_mem [MAX_POINTS];
  logic [2:0]  curve_mem [MAX_POINTS];
  logic [31:0] rtime_q;
  logic [15:0] rlevel_q;
  logic [2:0]  rcurve_q;
  logic [IW-1:0] raddr;
  logic          rd_en;

  logic [CW-1:0] cnt_q, cur_q;
  logic [15:0]   start_q;
  logic [31:0]   lt_q;
  logic          ltv_q;

  bei_in_t     req_q;
  logic [31:0] t0_q, t1_q;
  logic [15:0] l0_q, l1_q;
  logic [2:0]  shape_q;

  logic [32:0]    rem_q;
  logic [31:0]    den_q;
  logic [FW-1:0]  f_q, w_q;
  logic [DCW-1:0] dcnt_q;
  logic [31:0]    x_q, y_q, a_q;
  logic [2:0]     k_q;
  logic           mir_q;
  logic signed [65:0] prod_q;
  logic [15:0]    res_q;

  // combinational helpers
  logic [31:0] num, den;
  logic        div_skip;
  logic [32:0] rem_sh;
  logic signed [32:0] ma, mb;
  logic [16:0] diff;
  logic [FW-1:0] cube_base, cube_c;
  logic [31:0] tq30, w30;
  logic signed [AW-1:0] acc, acc_adj, acc_q;

  assign num      = (req_q.time_req >= t0_q) ? req_q.time_req - t0_q : 32'd0;
  assign den      = (t1_q > t0_q) ? t1_q - t0_q : 32'd0;
  assign div_skip = (den == 32'd0) || (num >= den);
  assign rem_sh   = {rem_q[31:0], 1'b0};
  assign diff     = {l1_q[15], l1_q} - {l0_q[15], l0_q};
  assign cube_base = (shape_q == CURVE_EASE_OUT) ? ONE - f_q : f_q;
  assign cube_c    = prod_q[FRAC_BITS +: FW];
  assign tq30      = {{(31 - FRAC_BITS){1'b0}}, f_q} << (30 - FRAC_BITS);
  assign w30       = mir_q ? Q30_ONE - prod_q[61:30] : prod_q[61:30];

  assign acc     = ({{(AW-16){l0_q[15]}}, l0_q} <<< FRAC_BITS) + AW'(prod_q);
  assign acc_adj = acc + (acc[AW-1] ? AW'(ONE - FW'(1)) : AW'(0));
  assign acc_q   = acc_adj >>> FRAC_BITS;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OP_MUL_XX:  begin ma = {1'b0, x_q}; mb = {1'b0, x_q};    end
      OP_MUL_YX:  begin ma = {1'b0, y_q}; mb = {1'b0, x_q};    end
      OP_MUL_XPI: begin ma = {1'b0, x_q}; mb = {1'b0, PI_Q30}; end
      OP_MUL_YA:  begin ma = {1'b0, y_q}; mb = {1'b0, a_q};    end
      OP_MUL_FIN: begin
        ma = {{16{diff[16]}}, diff};
        mb = {{(33 - FW){1'b0}}, w_q};
      end
      default: ;
    endcase
  end

  always_comb begin
    rd_en = 1'b1;
    raddr = cur_q[IW-1:0];
    case (cmd_i.op)
      OP_RD_LAST: raddr = IW'(cnt_q - CW'(1));
      OP_RD_PREV: raddr = IW'(cur_q - CW'(1));
      OP_RD_CUR:  raddr = cur_q[IW-1:0];
      default:    rd_en = 1'b0;
    endcase
  end

  // table memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_APPEND) begin
      time_mem[cnt_q[IW-1:0]]  <= req_q.time_req;
      level_mem[cnt_q[IW-1:0]] <= req_q.level;
      curve_mem[cnt_q[IW-1:0]] <= req_q.curve;
    end
    if (rd_en) begin
      rtime_q  <= time_mem[raddr];
      rlevel_q <= level_mem[raddr];
      rcurve_q <= curve_mem[raddr];
    end
  end

  // table control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      cur_q   <= '0;
      start_q <= '0;
      ltv_q   <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_CLEAR: begin
          cnt_q   <= '0;
          cur_q   <= '0;
          start_q <= req_q.level;
        end
        OP_POP:    cnt_q <= cnt_q - CW'(1);
        OP_APPEND: begin
          cnt_q <= cnt_q + CW'(1);
          cur_q <= '0;
        end
        OP_SAMP_BEGIN: begin
          if (ltv_q && (req_q.time_req < lt_q)) cur_q <= '0;
          ltv_q <= 1'b1;
        end
        OP_CUR_INC: cur_q <= cur_q + CW'(1);
        default: ;
      endcase
    end
  end

  // work registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LATCH:      req_q <= in_i;
      OP_SAMP_BEGIN: lt_q  <= req_q.time_req;
      OP_LOAD_END: begin
        t1_q    <= rtime_q;
        l1_q    <= rlevel_q;
        shape_q <= rcurve_q;
        t0_q    <= '0;
        l0_q    <= start_q;
      end
      OP_LOAD_PREV: begin
        t0_q <= rtime_q;
        l0_q <= rlevel_q;
      end
      OP_DIV_INIT: begin
        rem_q  <= {1'b0, num};
        den_q  <= den;
        dcnt_q <= '0;
        f_q    <= (den == 32'd0) ? '0 : (div_skip ? ONE - FW'(1) : '0);
      end
      OP_DIV_STEP: begin
        dcnt_q <= dcnt_q + DCW'(1);
        if (rem_sh >= {1'b0, den_q}) begin
          rem_q <= rem_sh - {1'b0, den_q};
          f_q   <= {f_q[FW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          f_q   <= {f_q[FW-2:0], 1'b0};
        end
      end
      OP_W_LIN:    w_q <= f_q;
      OP_CUBE_PRE: x_q <= {{(32 - FW){1'b0}}, cube_base};
      OP_CUBE_F2:  y_q <= prod_q[FRAC_BITS +: 32];
      OP_CUBE_FIN: w_q <= (shape_q == CURVE_EASE_OUT) ? ONE - cube_c : cube_c;
      OP_COS_U: begin
        // fold into the first half and mirror afterward
        if (tq30 > Q30_HALF) begin
          x_q   <= Q30_ONE - tq30;
          mir_q <= 1'b1;
        end else begin
          x_q   <= tq30;
          mir_q <= 1'b0;
        end
      end
      OP_SHX: x_q <= prod_q[61:30];
      OP_SHY: begin
        y_q <= prod_q[61:30];
        a_q <= CS_C5;
        k_q <= '0;
      end
      OP_HORNER: begin
        a_q <= horner_coef(k_q[1:0]) - prod_q[61:30];
        k_q <= k_q + 3'd1;
      end
      OP_COS_FIN: w_q <= w30[30 -: FW];
      OP_RESULT: begin
        if (acc_q > AW'(32767))        res_q <= 16'h7fff;
        else if (acc_q < -AW'(32768))  res_q <= 16'h8000;
        else                           res_q <= acc_q[15:0];
      end
      OP_RES_L0:    res_q <= l0_q;
      OP_RES_LAST:  res_q <= rlevel_q;
      OP_RES_START: res_q <= start_q;
      default: ;
    endcase
    if (cmd_i.op == OP_MUL_XX || cmd_i.op == OP_MUL_YX || cmd_i.op == OP_MUL_XPI ||
        cmd_i.op == OP_MUL_YA || cmd_i.op == OP_MUL_FIN) begin
      prod_q <= ma * mb;
    end
  end

  // output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_o <= 1'b0;
    end else begin
      strobe_o <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_o.sample   <= (req_q.cmd == CMD_ADD) ? 16'd0 : res_q;
      out_o.accepted <= cmd_i.ok;
    end
  end

  assign stat_o.is_add      = (req_q.cmd == CMD_ADD);
  assign stat_o.t_zero      = (req_q.time_req == 32'd0);
  assign stat_o.cnt_zero    = (cnt_q == '0);
  assign stat_o.cnt_full    = (cnt_q >= CW'(MAX_POINTS));
  assign stat_o.cur_end     = (cur_q >= cnt_q);
  assign stat_o.cur_zero    = (cur_q == '0);
  assign stat_o.t_lt_r      = (req_q.time_req < rtime_q);
  assign stat_o.div_skip    = div_skip;
  assign stat_o.div_last    = (dcnt_q == DCW'(FRAC_BITS - 1));
  assign stat_o.horner_done = (k_q == HORNER_STEPS);
  assign stat_o.curve       = shape_q;

endmodule
`default_nettype wire

/* hw/rtl/breakpoint_envelope_interpolator.sv */
// Top level: breakpoint envelope interpolator, controller plus datapath.
`default_nettype none
// A word is taken when start_i is high and busy_o low; its result is registered on
// out_o with a one-cycle strobe_o and cannot be held off. An add at time zero clears
// the table; any other add drops trailing points later than its time, reading and
// checking each, then appends. A sample walks the cursor, reading and checking each
// point passed (one table read port), then may run the serial divider and the
// shared multiplier for the curve weight.
module breakpoint_envelope_interpolator import bei_pkg::*; #(
  parameter int MAX_POINTS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  output logic         busy_o,
  input  wire bei_in_t in_i,
  output logic         strobe_o,
  output bei_out_t     out_o
);

  bei_cmd_t  cmd;
  bei_stat_t stat;

  bei_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  bei_dp #(
    .MAX_POINTS(MAX_POINTS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .strobe_o(strobe_o),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire
